// File: rtl/core/dkp_pkg.sv
// Package for the discrepancy kernel product block: beat types, fixed-point
// constants, configuration codes, controller states and command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package dkp_pkg;

    // Fixed-point formats.
    localparam int COORD_FRAC_BITS   = 16;
    localparam int PRODUCT_FRAC_BITS = 32;
    localparam int COORD_W           = COORD_FRAC_BITS + 1;      // Q0.F plus the 1.0 code
    localparam int TERM_W            = COORD_FRAC_BITS + 2;      // Q2.F
    localparam int PROD_W            = 56;                       // Q24.32
    localparam int NUM_W             = 2 * COORD_FRAC_BITS + 4;  // exact term numerator
    localparam int CENT_W            = COORD_FRAC_BITS + 4;

    // Shared multiplier: product halves by the term.
    localparam int MUL_A_W  = PROD_W / 2;
    localparam int MUL_B_W  = TERM_W;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int FULL_W   = PROD_W + TERM_W + 1;

    localparam logic [COORD_W-1:0] COORD_ONE  = COORD_W'(1) << COORD_FRAC_BITS;
    localparam logic [COORD_W-1:0] COORD_HALF = COORD_W'(1) << (COORD_FRAC_BITS - 1);
    localparam logic [PROD_W-1:0]  PROD_ONE   = PROD_W'(1) << PRODUCT_FRAC_BITS;
    localparam logic [PROD_W-1:0]  PROD_MAX   = {PROD_W{1'b1}};

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TYPE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TERM_KIND   = CFG_IDX_W'(1);

    localparam logic [1:0] KT_STAR = 2'd0;
    localparam logic [1:0] KT_SYMM = 2'd1;
    localparam logic [1:0] KT_CENT = 2'd2;

    localparam logic TK_TWO_POINT = 1'b0;
    localparam logic TK_ONE_POINT = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] coord_a;
        logic [COORD_W-1:0] coord_b;
        logic               last_coord;
    } t_in_beat;

    typedef struct packed {
        logic [PROD_W-1:0] kernel_value;
        logic              saturated;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_TERM,
        ST_LO,
        ST_HI,
        ST_ACC
    } t_state;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_LO,
        MUL_HI
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     term_en;
        logic     commit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic one_point;
        logic out_full;
    } t_dp_status;

endpackage

// File: rtl/core/dkp_ctrl.sv
// Sequencing state machine for the discrepancy kernel product block.
// Depends on dkp_pkg for states and the command/status structs.
`timescale 1ns / 1ps

module dkp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  dkp_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output dkp_pkg::t_dp_cmd    o_cmd
);
    import dkp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   can_commit;

    // A last beat may only retire when the output register is free or draining.
    assign can_commit = !i_status.last || !i_status.out_full || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.one_point ? ST_SQ : ST_TERM;
                end
            end
            ST_SQ:   n_state = ST_TERM;
            ST_TERM: n_state = ST_LO;
            ST_LO:   n_state = ST_HI;
            ST_HI:   n_state = ST_ACC;
            ST_ACC: begin
                if (!can_commit) begin
                    n_state = ST_ACC;
                end else if (i_in_valid) begin
                    n_state = i_status.one_point ? ST_SQ : ST_TERM;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_SQ;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_SQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SQ;
            end
            ST_TERM: begin
                o_cmd.term_en = 1'b1;
            end
            ST_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LO;
            end
            ST_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_HI;
            end
            ST_ACC: begin
                o_cmd.commit = can_commit;
                o_in_stall   = !can_commit;
                o_cmd.load   = can_commit && i_in_valid;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/core/dkp_datapath.sv
// Datapath of the discrepancy kernel product block: configuration registers,
// coordinate registers, term logic, shared multiplier, running product, output register.
// Depends on dkp_pkg.
`timescale 1ns / 1ps

module dkp_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [dkp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dkp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  dkp_pkg::t_in_beat               i_in_data,
    input  logic                            i_out_stall,
    input  dkp_pkg::t_dp_cmd                i_cmd,
    output dkp_pkg::t_dp_status             o_status,
    output logic                            o_out_valid,
    output dkp_pkg::t_out_beat              o_out_data
);
    import dkp_pkg::*;

    logic [1:0]          r_kernel_type;
    logic                r_term_kind;
    logic [COORD_W-1:0]  r_x;
    logic [COORD_W-1:0]  r_y;
    logic                r_last;
    logic [MUL_P_W-1:0]  r_mul;
    logic [MUL_P_W-1:0]  r_plo;
    logic [TERM_W-1:0]   r_term;
    logic [PROD_W-1:0]   r_prod;
    logic                r_ovf;
    logic                r_out_valid;
    t_out_beat           r_out;

    logic [COORD_W-1:0]  d, m, ex, ey;
    logic [CENT_W-1:0]   s_cent;
    logic [NUM_W-1:0]    num;
    logic [TERM_W-1:0]   n_term;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  n_mul;
    logic [FULL_W-1:0]   full;
    logic                sat;
    logic [PROD_W-1:0]   n_prod;
    logic                n_ovf;
    logic                symm, cent;

    assign symm = (r_kernel_type == KT_SYMM);
    assign cent = (r_kernel_type == KT_CENT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_type <= KT_STAR;
            r_term_kind   <= TK_TWO_POINT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KERNEL_TYPE: r_kernel_type <= i_cfg_data[1:0];
                REG_TERM_KIND:   r_term_kind   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Coordinates above one are clamped to one when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= (i_in_data.coord_a > COORD_ONE) ? COORD_ONE : i_in_data.coord_a;
            r_y    <= (i_in_data.coord_b > COORD_ONE) ? COORD_ONE : i_in_data.coord_b;
            r_last <= i_in_data.last_coord;
        end
    end

    always_comb begin
        d  = (r_x > r_y) ? r_x - r_y : r_y - r_x;
        m  = (r_x > r_y) ? r_x : r_y;
        ex = (r_x >= COORD_HALF) ? r_x - COORD_HALF : COORD_HALF - r_x;
        ey = (r_y >= COORD_HALF) ? r_y - COORD_HALF : COORD_HALF - r_y;
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_SQ: begin
                if (cent) begin
                    mul_a = MUL_A_W'(ex);
                    mul_b = MUL_B_W'(ex);
                end else if (symm) begin
                    mul_a = MUL_A_W'(r_x);
                    mul_b = MUL_B_W'(COORD_ONE - r_x);
                end else begin
                    mul_a = MUL_A_W'(r_x);
                    mul_b = MUL_B_W'(r_x);
                end
            end
            MUL_LO: begin
                mul_a = r_prod[MUL_A_W-1:0];
                mul_b = r_term;
            end
            MUL_HI: begin
                mul_a = r_prod[PROD_W-1:MUL_A_W];
                mul_b = r_term;
            end
            default: ;
        endcase
        n_mul = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_mul <= n_mul;
            if (i_cmd.mul_sel == MUL_HI) begin
                r_plo <= r_mul;
            end
        end
    end

    // Term in Q2.F, rounded once from the exact numerator, ties up.
    always_comb begin
        s_cent = CENT_W'(COORD_ONE) * CENT_W'(2) + CENT_W'(ex) + CENT_W'(ey) - CENT_W'(d)
                 + CENT_W'(1);
        num    = '0;
        n_term = '0;
        if (r_term_kind == TK_TWO_POINT) begin
            if (symm) begin
                n_term = {COORD_ONE - d, 1'b0};
            end else if (cent) begin
                n_term = s_cent[TERM_W:1];
            end else begin
                n_term = {COORD_ONE, 1'b0} - TERM_W'(m);
            end
        end else begin
            if (symm) begin
                num = (NUM_W'(1) << (2 * COORD_FRAC_BITS + 1))
                      + (NUM_W'(r_mul) << 2);
            end else if (cent) begin
                num = (NUM_W'(1) << (2 * COORD_FRAC_BITS + 1))
                      + (NUM_W'(ex) << COORD_FRAC_BITS) - NUM_W'(r_mul);
            end else begin
                num = (NUM_W'(3) << (2 * COORD_FRAC_BITS)) - NUM_W'(r_mul);
            end
            num    = num + (NUM_W'(1) << COORD_FRAC_BITS);
            n_term = num[COORD_FRAC_BITS+1 +: TERM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.term_en) begin
            r_term <= n_term;
        end
    end

    // Recombine the two partial products, round off F bits and saturate.
    always_comb begin
        full   = (FULL_W'(r_mul) << MUL_A_W) + FULL_W'(r_plo)
                 + (FULL_W'(1) << (COORD_FRAC_BITS - 1));
        sat    = |full[FULL_W-1:COORD_FRAC_BITS+PROD_W];
        n_prod = sat ? PROD_MAX : full[COORD_FRAC_BITS +: PROD_W];
        n_ovf  = r_ovf | sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= PROD_ONE;
            r_ovf  <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                r_prod <= PROD_ONE;
                r_ovf  <= 1'b0;
            end else begin
                r_prod <= n_prod;
                r_ovf  <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && r_last) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_last) begin
            r_out.kernel_value <= n_prod;
            r_out.saturated    <= n_ovf;
        end
    end

    assign o_status.last      = r_last;
    assign o_status.one_point = (r_term_kind == TK_ONE_POINT);
    assign o_status.out_full  = r_out_valid;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule

// File: rtl/core/discrepancy_kernel_product.sv
// Top level of the discrepancy kernel product block: joins the controller and
// the datapath. Depends on dkp_pkg, dkp_ctrl and dkp_datapath.
//
//   channel   direction  handshake             beat
//   in        input      i_in_valid/o_in_stall  t_in_beat  (coord_a, coord_b, last_coord)
//   out       output     o_out_valid/i_out_stall t_out_beat (kernel_value, saturated)
//   cfg       input      i_cfg_valid/o_cfg_ready index + data (kernel_type, term_kind)
//
// A two-point beat passes the TERM, LO, HI and ACC states to the product update,
// a one-point beat the SQ state first; the next beat is taken on the update cycle
// itself. The order follows the single 28x18 multiplier, used once for the
// one-point square and twice for the two halves of the 56-bit running product.
// Reset is synchronous and active low; it restores the product to one, clears
// the saturation flag and both configuration registers, and empties the output
// register.
// A last beat whose result finds the output register still held stalls the
// input until the waiting result is taken; beats that are not last never wait.
`timescale 1ns / 1ps

module discrepancy_kernel_product (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  dkp_pkg::t_in_beat               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output dkp_pkg::t_out_beat              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dkp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dkp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dkp_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Configuration writes are taken in any cycle; software writes only when idle.
    assign o_cfg_ready = 1'b1;

    dkp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    dkp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // After a beat is taken, the block is busy for at least the next cycle.
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> o_in_stall)
        else $error("input taken while a beat is still in work");

    // Retiring a last beat always presents a result on the next cycle.
    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.commit && status.last) |=> o_out_valid)
        else $error("last beat retired without a result");

    // A result taken is gone next cycle unless a new one was loaded.
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !(cmd.commit && status.last)) |=> !o_out_valid)
        else $error("result delivered twice");

    // A last beat never overwrites a result that is still held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.commit && status.last && o_out_valid) |-> !i_out_stall)
        else $error("held result overwritten");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for discrepancy_kernel_product: a directed table, then
// random points per kernel setting, checked by an in-bench predictor or typed rows.
// Depends on dkp_pkg and the discrepancy_kernel_product RTL.
`timescale 1ns / 1ps

module tb_top;

    import dkp_pkg::*;

    // Kernel code 3 has no kind of its own; the block treats it as the star kernel.
    localparam logic [1:0] KT_UNUSED = 2'd3;

    localparam int MAX_WAIT      = 19;   // longest idle or stall drawn per beat
    localparam int SETTLE_CYCLES = 12;   // long enough for a one-point beat to land
    localparam int DEEP_DIMS     = 45;   // long enough for terms near 1.5 to saturate
    localparam int PHASE_BEATS   = 36;   // eight settings; with the last point's overrun
                                         // about 430 random beats

    // Products that can be read straight off the kernel formulas.
    localparam logic [PROD_W-1:0] P_ZERO  = '0;
    localparam logic [PROD_W-1:0] P_ONE   = PROD_ONE;
    localparam logic [PROD_W-1:0] P_1P125 = 56'h1_2000_0000;
    localparam logic [PROD_W-1:0] P_1P5   = 56'h1_8000_0000;
    localparam logic [PROD_W-1:0] P_TWO   = 56'h2_0000_0000;
    localparam logic [PROD_W-1:0] P_FOUR  = 56'h4_0000_0000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_beat              in_beat   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_beat;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    discrepancy_kernel_product dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: its own copy of the running product, the sticky flag and
    // the two registers, advanced once per accepted input beat.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] model_product = PROD_ONE;
    logic              model_sat     = 1'b0;
    logic [1:0]        model_kt      = KT_STAR;
    logic              model_tk      = TK_TWO_POINT;

    t_out_beat expected_products [$];
    int        failures = 0;

    function automatic logic [63:0] clamp_to_one(input logic [COORD_W-1:0] raw);
        return (raw > COORD_ONE) ? 64'(COORD_ONE) : 64'(raw);
    endfunction

    // Per-dimension term in Q2.16. The exact numerator is built at scale 2^33
    // and rounded once, ties up, as the block is specified to do.
    function automatic logic [TERM_W-1:0] kernel_term(input logic [1:0] kt, input logic tk,
                                                      input logic [COORD_W-1:0] xa,
                                                      input logic [COORD_W-1:0] ya);
        logic [63:0] x, y, one, half, d, ex, ey, m, num;
        x    = clamp_to_one(xa);
        y    = clamp_to_one(ya);
        one  = 64'(COORD_ONE);
        half = 64'(COORD_HALF);
        d    = (x > y) ? x - y : y - x;
        ex   = (x > half) ? x - half : half - x;
        ey   = (y > half) ? y - half : half - y;
        m    = (x > y) ? x : y;
        if (tk == TK_TWO_POINT) begin
            case (kt)
                KT_SYMM: num = 2 * (one - d) * 2 * one;
                KT_CENT: num = (2 * one + ex + ey - d) * one;
                default: num = (2 * one - m) * 2 * one;
            endcase
        end else begin
            case (kt)
                KT_SYMM: num = 2 * one * one + 4 * x * (one - x);
                KT_CENT: num = 2 * one * one + ex * one - ex * ex;
                default: num = 3 * one * one - x * x;
            endcase
        end
        num = (num + (64'd1 << COORD_FRAC_BITS)) >> (COORD_FRAC_BITS + 1);
        return num[TERM_W-1:0];
    endfunction

    // Multiplies the beat's term into the product, clamping at the top of the
    // 56-bit range. A last beat yields the product and restarts it at one.
    task automatic advance_product(input t_in_beat beat, output logic has_res,
                                   output t_out_beat res);
        logic [127:0]      full;
        logic [TERM_W-1:0] term;
        term = kernel_term(model_kt, model_tk, beat.coord_a, beat.coord_b);
        full = 128'(model_product) * 128'(term);
        full = (full + (128'd1 << (COORD_FRAC_BITS - 1))) >> COORD_FRAC_BITS;
        if (full > 128'(PROD_MAX)) begin
            model_product = PROD_MAX;
            model_sat     = 1'b1;
        end else begin
            model_product = full[PROD_W-1:0];
        end
        has_res          = beat.last_coord;
        res.kernel_value = model_product;
        res.saturated    = model_sat;
        if (beat.last_coord) begin
            model_product = PROD_ONE;
            model_sat     = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall per beat, with stretches of none, and a
    // field-by-field check of each accepted beat against the oldest product.
    // ------------------------------------------------------------------
    int rx_hold  = 0;
    bit rx_burst = 1'b0;

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("%t: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk) begin
        t_out_beat want;
        if (!rst_n) begin
            rx_hold = 0;
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_products.size() == 0) begin
                    note_failure($sformatf("unexpected product beat %h / %b",
                                           out_beat.kernel_value, out_beat.saturated));
                end else begin
                    want = expected_products.pop_front();
                    if (out_beat.kernel_value !== want.kernel_value) begin
                        note_failure($sformatf("kernel_value: expected %h, got %h",
                                               want.kernel_value, out_beat.kernel_value));
                    end
                    if (out_beat.saturated !== want.saturated) begin
                        note_failure($sformatf("saturated: expected %b, got %b",
                                               want.saturated, out_beat.saturated));
                    end
                end
                if ($urandom_range(0, 7) == 0) begin
                    rx_burst = !rx_burst;
                end
                rx_hold = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (rx_hold != 0) begin
                rx_hold--;
            end
            out_stall <= (rx_hold != 0);
        end
    end

    // ------------------------------------------------------------------
    // Input side. Every task is entered and left in the time step of a
    // rising edge, so each drive is a single nonblocking update per step.
    // ------------------------------------------------------------------
    bit tx_burst = 1'b0;

    // Offers one beat until it is taken, predicts it, then idles for a
    // random gap. With no gap, valid stays high for the next beat.
    task automatic send_coord(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b,
                              input logic last, input logic typed, input t_out_beat typed_res);
        t_in_beat  beat;
        t_out_beat res;
        logic      has_res;
        int        gap;
        beat.coord_a    = a;
        beat.coord_b    = b;
        beat.last_coord = last;
        in_beat  <= beat;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        advance_product(beat, has_res, res);
        if (has_res) begin
            expected_products.push_back(typed ? typed_res : res);
        end
        gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the input back until every product has come out, then lets a
    // beat that is not last finish its update before anything else happens.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_products.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Both registers are rewritten at every change. The spare upper bit of the
    // term kind write is random, since only bit 0 is kept.
    task automatic apply_config(input logic [1:0] kt, input logic tk);
        wait_idle();
        write_reg(REG_KERNEL_TYPE, kt);
        write_reg(REG_TERM_KIND, {1'($urandom_range(0, 1)), tk});
        model_kt = kt;
        model_tk = tk;
    endtask

    // Mostly in range with the ends picked often; some codes above one.
    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return COORD_ONE;
            2:       return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
            default: return COORD_W'($urandom_range(0, 1 << COORD_FRAC_BITS));
        endcase
    endfunction

    // One point: a few dimensions with random coordinates, or now and then a
    // long point with coordinates near the term's peak, so that the product
    // can climb into saturation and keep multiplying the clamped value.
    task automatic send_point(inout int count);
        int                 dims;
        bit                 deep;
        logic [COORD_W-1:0] a, b;
        deep = ($urandom_range(0, 4) == 0);
        dims = deep ? DEEP_DIMS : $urandom_range(1, 6);
        if ($urandom_range(0, 5) == 0) begin
            tx_burst = !tx_burst;
        end
        for (int i = 0; i < dims; i++) begin
            a = rand_coord();
            b = rand_coord();
            if (deep && $urandom_range(0, 11) != 0) begin
                if (model_tk == TK_TWO_POINT) begin
                    case (model_kt)
                        KT_SYMM: b = a;
                        KT_CENT: begin
                            a = $urandom_range(0, 1) ? COORD_ONE : '0;
                            b = $urandom_range(0, 1) ? COORD_ONE : '0;
                        end
                        default: begin
                            a = COORD_W'($urandom_range(0, 1500));
                            b = COORD_W'($urandom_range(0, 1500));
                        end
                    endcase
                end else begin
                    case (model_kt)
                        KT_SYMM: a = COORD_W'($urandom_range(32368, 33168));
                        KT_CENT: a = $urandom_range(0, 1) ? COORD_ONE : '0;
                        default: a = COORD_W'($urandom_range(0, 2000));
                    endcase
                end
            end
            send_coord(a, b, i == dims - 1, 1'b0, '0);
            count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table. Rows with typed set carry a product worked out by
    // hand; the rest are checked against the predictor.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [1:0]         kt;
        logic               tk;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        logic               last;
        logic               typed;
        t_out_beat          res;
    } t_dir_row;

    t_dir_row directed_rows [0:23] = '{
        // Star, two-point: term is 2 - max(x, y).
        '{KT_STAR,   TK_TWO_POINT, 17'h00000, 17'h00000, 1'b1, 1'b1, '{P_TWO,   1'b0}},
        '{KT_STAR,   TK_TWO_POINT, COORD_ONE, COORD_ONE, 1'b1, 1'b1, '{P_ONE,   1'b0}},
        // A coordinate code above one counts as one.
        '{KT_STAR,   TK_TWO_POINT, 17'h1FFFF, 17'h00000, 1'b1, 1'b1, '{P_ONE,   1'b0}},
        // Two dimensions of term 2 before the end of the point.
        '{KT_STAR,   TK_TWO_POINT, 17'h00000, 17'h00000, 1'b0, 1'b0, '{P_ZERO,  1'b0}},
        '{KT_STAR,   TK_TWO_POINT, 17'h00000, 17'h00000, 1'b1, 1'b1, '{P_FOUR,  1'b0}},
        '{KT_STAR,   TK_TWO_POINT, 17'h0FFFF, 17'h10001, 1'b1, 1'b0, '{P_ZERO,  1'b0}},
        // Symmetric, two-point: term is 2(1 - |x - y|), zero at full distance.
        '{KT_SYMM,   TK_TWO_POINT, 17'h00000, COORD_ONE, 1'b1, 1'b1, '{P_ZERO,  1'b0}},
        '{KT_SYMM,   TK_TWO_POINT, 17'h08000, 17'h08000, 1'b1, 1'b1, '{P_TWO,   1'b0}},
        '{KT_SYMM,   TK_TWO_POINT, COORD_ONE, 17'h1FFFF, 1'b1, 1'b1, '{P_TWO,   1'b0}},
        '{KT_SYMM,   TK_TWO_POINT, 17'h0AAAA, 17'h15555, 1'b1, 1'b0, '{P_ZERO,  1'b0}},
        // Centered, two-point.
        '{KT_CENT,   TK_TWO_POINT, 17'h00000, 17'h00000, 1'b1, 1'b1, '{P_1P5,   1'b0}},
        '{KT_CENT,   TK_TWO_POINT, 17'h00000, COORD_ONE, 1'b1, 1'b1, '{P_ONE,   1'b0}},
        '{KT_CENT,   TK_TWO_POINT, 17'h01234, 17'h0D431, 1'b0, 1'b0, '{P_ZERO,  1'b0}},
        '{KT_CENT,   TK_TWO_POINT, 17'h15555, 17'h0AAAA, 1'b1, 1'b0, '{P_ZERO,  1'b0}},
        // The unused kernel code falls back to star.
        '{KT_UNUSED, TK_TWO_POINT, 17'h00000, 17'h00000, 1'b1, 1'b1, '{P_TWO,   1'b0}},
        // One-point kernels ignore coord_b.
        '{KT_STAR,   TK_ONE_POINT, 17'h00000, 17'h1FFFF, 1'b1, 1'b1, '{P_1P5,   1'b0}},
        '{KT_STAR,   TK_ONE_POINT, COORD_ONE, 17'h00000, 1'b1, 1'b1, '{P_ONE,   1'b0}},
        '{KT_SYMM,   TK_ONE_POINT, 17'h08000, 17'h00000, 1'b1, 1'b1, '{P_1P5,   1'b0}},
        '{KT_SYMM,   TK_ONE_POINT, 17'h00000, 17'h00000, 1'b1, 1'b1, '{P_ONE,   1'b0}},
        '{KT_SYMM,   TK_ONE_POINT, 17'h1ABCD, 17'h00000, 1'b1, 1'b1, '{P_ONE,   1'b0}},
        '{KT_CENT,   TK_ONE_POINT, 17'h08000, 17'h00000, 1'b1, 1'b1, '{P_ONE,   1'b0}},
        '{KT_CENT,   TK_ONE_POINT, 17'h00000, 17'h00000, 1'b1, 1'b1, '{P_1P125, 1'b0}},
        '{KT_CENT,   TK_ONE_POINT, 17'h0FFFF, 17'h1FFFF, 1'b1, 1'b0, '{P_ZERO,  1'b0}},
        '{KT_UNUSED, TK_ONE_POINT, 17'h0AAAA, 17'h15555, 1'b1, 1'b0, '{P_ZERO,  1'b0}}
    };

    logic [1:0] kernel_codes [4] = '{KT_STAR, KT_SYMM, KT_CENT, KT_UNUSED};
    logic       term_codes   [2] = '{TK_TWO_POINT, TK_ONE_POINT};

    // ------------------------------------------------------------------
    // Sequence: reset, directed table, then one random phase per setting.
    // Each configuration change drains the block first, which also makes
    // the sender wait for every outstanding product.
    // ------------------------------------------------------------------
    initial begin
        int phase_beats;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        apply_config(KT_STAR, TK_TWO_POINT);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kt != model_kt || directed_rows[i].tk != model_tk) begin
                apply_config(directed_rows[i].kt, directed_rows[i].tk);
            end
            send_coord(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
                       directed_rows[i].typed, directed_rows[i].res);
        end

        foreach (kernel_codes[k]) begin
            foreach (term_codes[t]) begin
                apply_config(kernel_codes[k], term_codes[t]);
                phase_beats = 0;
                while (phase_beats < PHASE_BEATS) begin
                    send_point(phase_beats);
                end
            end
        end

        wait_idle();
        if (failures == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
